// ===== hdl/a2f_pkg.sv =====
// ----------------------------------------------------------------------------
// a2f_pkg
// Shared types, codes and helpers for the sample-to-float32 pipeline.
// ----------------------------------------------------------------------------
package a2f_pkg;

  localparam int SampleW = 64;
  localparam int FloatW  = 32;
  localparam int MantW   = 53;   // normalized significand, leading one at bit 52
  localparam int ExpW    = 12;   // signed biased single exponent

  // sample_format codes
  localparam logic [2:0] FMT_PCM16   = 3'd0;
  localparam logic [2:0] FMT_PCM24   = 3'd1;
  localparam logic [2:0] FMT_PCM32   = 3'd2;
  localparam logic [2:0] FMT_FLOAT32 = 3'd3;
  localparam logic [2:0] FMT_FLOAT64 = 3'd4;

  // register indexes
  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_LITTLE = 1'b1;

  // what travels down the pipe
  localparam logic [1:0] KIND_ZERO = 2'd0;  // signed zero
  localparam logic [1:0] KIND_BITS = 2'd1;  // final pattern already known
  localparam logic [1:0] KIND_NUM  = 2'd2;  // needs normalize and round

  typedef struct packed {
    logic [1:0]       kind;
    logic             sign;
    logic [FloatW-1:0] bits;
    logic             is_dbl;
    logic [MantW-1:0] mag;    // pcm magnitude (low 32) or double significand with hidden one
    logic [10:0]      expo;   // double exponent or pcm bias offset
  } unp_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic                    sign;
    logic [FloatW-1:0]       bits;
    logic [MantW-1:0]        mant;
    logic signed [ExpW-1:0]  bexp;
  } nrm_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic                    sign;
    logic [FloatW-1:0]       bits;
    logic [24:0]             q;
    logic signed [ExpW-1:0]  bexp;
    logic                    norm;
  } rnd_t;

  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    logic       hit;
    n   = 6'd32;
    hit = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 6'(31 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// ===== hdl/a2f_unpack.sv =====
// ----------------------------------------------------------------------------
// a2f_unpack
// Stage 1: byte assembly, format decode, PCM magnitude, float64 specials.
// ----------------------------------------------------------------------------
module a2f_unpack import a2f_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [SampleW-1:0] raw,
  input  logic [2:0]         fmt,
  input  logic               little,
  output logic               out_vld,
  output unp_t               out_d
);

  logic  vld_r;
  unp_t  d_r, d_nxt;
  logic [15:0] w16;
  logic [23:0] w24;
  logic [31:0] w32, sx, mag32;
  logic [63:0] w64;

  always_comb begin
    w16 = little ? raw[15:0] : {raw[7:0], raw[15:8]};
    w24 = little ? raw[23:0] : {raw[7:0], raw[15:8], raw[23:16]};
    w32 = little ? raw[31:0] : {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
    w64 = little ? raw : {raw[7:0], raw[15:8], raw[23:16], raw[31:24],
                          raw[39:32], raw[47:40], raw[55:48], raw[63:56]};
    d_nxt        = '0;
    sx           = '0;
    unique case (fmt)
      FMT_PCM16: begin
        sx = {{16{w16[15]}}, w16};
        d_nxt.expo = 11'd112;
      end
      FMT_PCM24: begin
        sx = {{8{w24[23]}}, w24};
        d_nxt.expo = 11'd104;
      end
      FMT_PCM32: begin
        sx = w32;
        d_nxt.expo = 11'd96;
      end
      default: sx = '0;
    endcase
    mag32 = sx[31] ? (~sx + 32'd1) : sx;
    unique case (fmt)
      FMT_PCM16, FMT_PCM24, FMT_PCM32: begin
        d_nxt.sign = sx[31];
        d_nxt.mag  = {21'd0, mag32};
        d_nxt.kind = (mag32 == '0) ? KIND_ZERO : KIND_NUM;
        if (mag32 == '0) d_nxt.sign = 1'b0;
      end
      FMT_FLOAT32: begin
        d_nxt.kind = KIND_BITS;
        d_nxt.bits = w32;
      end
      FMT_FLOAT64: begin
        d_nxt.sign   = w64[63];
        d_nxt.is_dbl = 1'b1;
        d_nxt.expo   = w64[62:52];
        d_nxt.mag    = {1'b1, w64[51:0]};
        if (w64[62:52] == 11'h7FF) begin
          d_nxt.kind = KIND_BITS;
          // infinity, or quiet NaN keeping the top fraction bits
          d_nxt.bits = (w64[51:0] == '0) ? {w64[63], 31'h7F800000} :
                       {w64[63], 9'h1FF, w64[50:29]};
        end else if (w64[62:52] == 11'd0) begin
          d_nxt.kind = KIND_ZERO;   // double subnormals are far below single range
        end else begin
          d_nxt.kind = KIND_NUM;
        end
      end
      default: d_nxt.kind = KIND_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

// ===== hdl/a2f_norm.sv =====
// ----------------------------------------------------------------------------
// a2f_norm
// Stage 2: leading-one search for PCM, common significand and exponent.
// ----------------------------------------------------------------------------
module a2f_norm import a2f_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  unp_t in_d,
  output logic out_vld,
  output nrm_t out_d
);

  logic vld_r;
  nrm_t d_r, d_nxt;
  logic [5:0] lz;

  always_comb begin
    lz         = lzc32(in_d.mag[31:0]);
    d_nxt.kind = in_d.kind;
    d_nxt.sign = in_d.sign;
    d_nxt.bits = in_d.bits;
    if (in_d.is_dbl) begin
      d_nxt.mant = in_d.mag;
      d_nxt.bexp = ExpW'($signed({1'b0, in_d.expo})) - ExpW'(896);
    end else begin
      d_nxt.mant = MantW'(in_d.mag[31:0]) << (6'd21 + lz[4:0]);
      d_nxt.bexp = ExpW'($signed({1'b0, in_d.expo})) + ExpW'(31) - ExpW'(lz);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

// ===== hdl/a2f_round.sv =====
// ----------------------------------------------------------------------------
// a2f_round
// Stage 3: subnormal alignment and round to nearest even at 24 bits.
// ----------------------------------------------------------------------------
module a2f_round import a2f_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  nrm_t in_d,
  output logic out_vld,
  output rnd_t out_d
);

  logic vld_r;
  rnd_t d_r, d_nxt;
  logic [4:0]  dsh;
  logic [77:0] x;
  logic        up;

  always_comb begin
    if (in_d.bexp > 0) begin
      dsh = 5'd0;
    end else if (in_d.bexp < -ExpW'(23)) begin
      dsh = 5'd25;
    end else begin
      dsh = 5'(ExpW'(1) - in_d.bexp);
    end
    x  = {in_d.mant, 25'd0} >> dsh;
    up = x[53] & ((|x[52:0]) | x[54]);
    d_nxt.kind = in_d.kind;
    d_nxt.sign = in_d.sign;
    d_nxt.bits = in_d.bits;
    d_nxt.q    = {1'b0, x[77:54]} + 25'(up);
    d_nxt.bexp = in_d.bexp;
    d_nxt.norm = (dsh == 5'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

// ===== hdl/a2f_pack.sv =====
// ----------------------------------------------------------------------------
// a2f_pack
// Stage 4: exponent merge, overflow to infinity, output register.
// ----------------------------------------------------------------------------
module a2f_pack import a2f_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  rnd_t              in_d,
  output logic              out_vld,
  output logic [FloatW-1:0] out_bits
);

  logic              vld_r;
  logic [FloatW-1:0] bits_r, bits_nxt;
  logic [31:0]       sum;

  always_comb begin
    // hidden bit of q adds one to the exponent field, a rounding carry two
    sum = {1'b0, in_d.bexp[7:0] - 8'd1, 23'd0} + {7'd0, in_d.q};
    unique case (in_d.kind)
      KIND_BITS: bits_nxt = in_d.bits;
      KIND_NUM: begin
        if (!in_d.norm) begin
          bits_nxt = {in_d.sign, 7'd0, in_d.q[23:0]};
        end else if (in_d.bexp >= ExpW'(255) || sum[30:23] == 8'hFF) begin
          bits_nxt = {in_d.sign, 31'h7F800000};
        end else begin
          bits_nxt = {in_d.sign, sum[30:0]};
        end
      end
      default: bits_nxt = {in_d.sign, 31'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      bits_r <= bits_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_bits = bits_r;

endmodule

// ===== hdl/audio_sample_to_float32_top.sv =====
// ----------------------------------------------------------------------------
// audio_sample_to_float32_top
// Converts raw PCM16/24/32, float32 or float64 sample bytes to float32.
// ----------------------------------------------------------------------------
// Four-stage pipeline, one sample per clock unless out_stall holds a result.
// out_valid rises once a sample has passed the unpack, norm, round and pack
// registers. Stages: byte assembly and decode, leading-one normalize,
// round to nearest even, exponent pack into the output register.
// One enable moves the whole pipe; it stops only while a result sits in the
// output register with out_stall high, so in_stall follows that condition.
// Write sample_format (0x0) and little_endian (0x4) over APB only while no
// transaction is in flight; both read back on prdata.
module audio_sample_to_float32_top import a2f_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [SampleW-1:0] in_sample_bytes,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FloatW-1:0]  out_float_bits,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [2:0] fmt_r;
  logic       little_r;
  logic       en;
  logic       v1, v2, v3;
  unp_t       d1;
  nrm_t       d2;
  rnd_t       d3;

  // register file; register index lives in paddr[2]
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_PCM16;
      little_r <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_FORMAT: fmt_r    <= pwdata[2:0];
        REG_LITTLE: little_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FORMAT: prdata = {29'd0, fmt_r};
      REG_LITTLE: prdata = {31'd0, little_r};
      default:    prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // whole pipe advances unless the finished result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  a2f_unpack u_unpack (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_valid), .raw(in_sample_bytes),
    .fmt(fmt_r), .little(little_r), .out_vld(v1), .out_d(d1)
  );

  a2f_norm u_norm (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v1), .in_d(d1),
    .out_vld(v2), .out_d(d2)
  );

  a2f_round u_round (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v2), .in_d(d2),
    .out_vld(v3), .out_d(d3)
  );

  a2f_pack u_pack (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v3), .in_d(d3),
    .out_vld(out_valid), .out_bits(out_float_bits)
  );

endmodule

// ===== tb/sv/audio_sample_to_float32_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_sample_to_float32_top_tb
// Self-checking bench: raw sample bytes go in, every float32 result is
// compared with a bit-exact integer model of the conversion.
// ----------------------------------------------------------------------------
module audio_sample_to_float32_top_tb;
  import a2f_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [SampleW-1:0] in_sample_bytes = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [FloatW-1:0]  out_float_bits;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // register byte addresses
  localparam logic [2:0] ADDR_FORMAT = 3'd0;
  localparam logic [2:0] ADDR_LITTLE = 3'd4;
  localparam logic [2:0] FMT_UNSUP   = 3'd5;
  localparam logic [2:0] FMT_SPARE   = 3'd7;   // reserved code, also unsupported

  logic [SampleW-1:0] pending_samples[$];
  logic [FloatW-1:0]  expected_floats[$];

  // bench copy of the registers; only changed while the pipe is empty
  logic [2:0] cur_format = FMT_PCM16;
  logic       cur_little = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_hold = 0;
  int error_count = 0;

  always #5 clk = ~clk;

  audio_sample_to_float32_top u_top (.*);

  // --------------------------------------------------------------------------
  // Conversion model
  // --------------------------------------------------------------------------
  function automatic logic [63:0] assemble_word(logic [63:0] raw, int n, bit little);
    logic [63:0] w;
    w = '0;
    for (int i = 0; i < n; i++) begin
      if (little) w[8*i +: 8] = raw[8*i +: 8];
      else        w[8*(n-1-i) +: 8] = raw[8*i +: 8];
    end
    return w;
  endfunction

  // sign * mag * 2^e rounded to single, nearest even
  function automatic logic [31:0] round_single(bit sgn, logic [63:0] mag, int e);
    int p, shift, lsb, be;
    logic [63:0] q, rem, half;
    logic [31:0] s;
    s = {sgn, 31'b0};
    if (mag == 0) return s;
    p = 63;
    while (!mag[p]) p--;
    shift = p - 23;
    if (-149 - e > shift) shift = -149 - e;
    if (shift <= 0) begin
      q = mag << (-shift);
    end else if (shift >= 64) begin
      q = 0;
      if (shift == 64 && mag > 64'h8000_0000_0000_0000) q = 1;
    end else begin
      rem  = mag & ((64'd1 << shift) - 1);
      half = 64'd1 << (shift - 1);
      q    = mag >> shift;
      if (rem > half || (rem == half && q[0])) q++;
    end
    lsb = e + shift;
    if (q >= (64'd1 << 24)) begin
      q >>= 1;
      lsb++;
    end
    if (q >= (64'd1 << 23)) begin
      be = lsb + 150;
      if (be >= 255) return s | 32'h7F80_0000;
      return s | (32'(be) << 23) | (q[31:0] & 32'h007F_FFFF);
    end
    return s | q[31:0];
  endfunction

  function automatic logic [31:0] pcm_to_single(logic [63:0] w, int bits, int e);
    if (w[bits-1]) return round_single(1'b1, (64'd1 << bits) - w, e);
    return round_single(1'b0, w, e);
  endfunction

  function automatic logic [31:0] double_to_single(logic [63:0] w);
    logic [10:0] ex;
    logic [51:0] frac;
    ex   = w[62:52];
    frac = w[51:0];
    if (ex == 11'h7FF) begin
      if (frac == 0) return {w[63], 31'h7F80_0000};
      return {w[63], 31'h7FC0_0000} | {10'b0, frac[50:29]};
    end
    if (ex == 0) return round_single(w[63], {12'b0, frac}, -1074);
    return round_single(w[63], {11'b0, 1'b1, frac}, int'(ex) - 1075);
  endfunction

  function automatic logic [31:0] sample_to_single(logic [63:0] raw, logic [2:0] fmt,
                                                   bit little);
    case (fmt)
      FMT_PCM16:   return pcm_to_single(assemble_word(raw, 2, little), 16, -15);
      FMT_PCM24:   return pcm_to_single(assemble_word(raw, 3, little), 24, -23);
      FMT_PCM32:   return pcm_to_single(assemble_word(raw, 4, little), 32, -31);
      FMT_FLOAT32: return 32'(assemble_word(raw, 4, little));
      FMT_FLOAT64: return double_to_single(assemble_word(raw, 8, little));
      default:     return '0;
    endcase
  endfunction

  // word -> raw file bytes for the current order; unused bytes get noise
  function automatic logic [63:0] word_to_bytes(logic [63:0] w, int n, bit little);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      if (little) raw[8*i +: 8] = w[8*i +: 8];
      else        raw[8*i +: 8] = w[8*(n-1-i) +: 8];
    end
    return raw;
  endfunction

  function automatic int container_bytes(logic [2:0] fmt);
    case (fmt)
      FMT_PCM16:   return 2;
      FMT_PCM24:   return 3;
      FMT_PCM32:   return 4;
      FMT_FLOAT32: return 4;
      default:     return 8;
    endcase
  endfunction

  // random word biased toward interesting regions of float64 and PCM32
  function automatic logic [63:0] random_word(logic [2:0] fmt);
    logic [63:0] w;
    w = {$urandom, $urandom};
    if (fmt == FMT_FLOAT64) begin
      case ($urandom_range(0, 5))
        0, 1: w[62:52] = 11'(1023 + $signed($urandom_range(0, 300)) - 160);
        2:    w[62:52] = 11'(1023 - 149 + $urandom_range(0, 30) - 15);
        3:    w[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
        4:    w[28:0] = $urandom_range(0, 1) ? 29'h1000_0000 : 29'h0;  // ties
        default: ;
      endcase
    end else if (fmt == FMT_PCM32 && $urandom_range(0, 2) == 0) begin
      w[6:0] = 7'h40;   // exact halfway for small shifts
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one transaction per accepting edge, payload held while stalled
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [63:0] nxt;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_floats.push_back(sample_to_single(in_sample_bytes, cur_format, cur_little));
      if (!(in_valid && in_stall)) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_samples.pop_front();
          in_sample_bytes <= nxt;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare against the oldest expectation, then pick next stall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_floats.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result %h", out_float_bits);
        end else begin
          want = expected_floats.pop_front();
          if (want !== out_float_bits) begin
            error_count++;
            if (error_count <= 10)
              $display("float_bits mismatch: expected %h actual %h", want, out_float_bits);
          end
        end
      end
      // a long hold-off lets the pipe fill and back-pressure the sender
      if (stall_hold > 0) begin
        stall_hold <= stall_hold - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and phase control
  // --------------------------------------------------------------------------
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // wait until every transaction has come out, plus the pipe latency
  task automatic drain;
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_floats.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(logic [2:0] fmt, bit little);
    reg_write(ADDR_FORMAT, {29'b0, fmt});
    reg_write(ADDR_LITTLE, {31'b0, little});
    cur_format = fmt;
    cur_little = little;
  endtask

  initial begin
    logic [63:0] dir_words[$];
    int nb;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes and specials per format, in both byte orders
    for (int k = 0; k < 12; k++) begin
      set_config(3'(k % 6), k >= 6);
      nb = container_bytes(cur_format);
      dir_words = {64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1};
      case (cur_format)
        FMT_PCM16: dir_words = {dir_words, 64'h7FFF, 64'h8000, 64'hFFFF};
        FMT_PCM24: dir_words = {dir_words, 64'h7F_FFFF, 64'h80_0000};
        FMT_PCM32: dir_words = {dir_words, 64'h7FFF_FFFF, 64'h8000_0000,
                                64'h0100_0001, 64'h0100_0003, 64'h0100_0000};
        FMT_FLOAT32: dir_words = {dir_words, 64'h7FC0_0001, 64'h8000_0000};
        FMT_FLOAT64: dir_words = {dir_words,
          64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,   // infinities
          64'h7FF8_0000_2000_0001, 64'hFFF0_0000_0000_0001,   // NaNs
          64'h47F0_0000_0000_0000, 64'h47EF_FFFF_FFFF_FFFF,   // overflow
          64'h36A0_0000_0000_0000, 64'h3690_0000_0000_0000,   // tiny, halfway
          64'h3698_0000_0000_0000, 64'h8000_0000_0000_0000,
          64'h3FF0_0000_1000_0000, 64'h3FF0_0000_3000_0000,   // ties
          64'h380F_FFFF_F000_0000};                          // rounds to normal
        default: ;
      endcase
      foreach (dir_words[i]) pending_samples.push_back(word_to_bytes(dir_words[i], nb, cur_little));
      drain();
    end

    // random phases: every format, byte order and idling mix
    for (int ph = 0; ph < 16; ph++) begin
      set_config(ph == 15 ? FMT_SPARE : (ph == 14 ? FMT_UNSUP : 3'(ph % 5)), ph[1]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      if (ph == 4) stall_hold = 200;   // sender keeps offering meanwhile
      nb = container_bytes(cur_format);
      for (int i = 0; i < 64; i++) begin
        if ($urandom_range(0, 4) == 0)
          pending_samples.push_back({$urandom, $urandom});
        else
          pending_samples.push_back(word_to_bytes(random_word(cur_format), nb, cur_little));
        // sender pause mid-phase until every result is back
        if (ph == 6 && i == 32) drain();
      end
      drain();
    end

    set_config(FMT_PCM16, 1'b0);
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("audio_sample_to_float32_top regression: pass");
    else
      $display("audio_sample_to_float32_top regression: fail");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("audio_sample_to_float32_top regression: fail");
    $finish;
  end

endmodule
